>>> hdl/chull_pkg.sv
// Package: shared types and constants of the convex hull core.
`default_nettype none
package chull_pkg;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    // smallest point set that gets a scan
    localparam int MIN_HULL_POINTS = 4;

    // per-point control bits carried through the queue
    typedef struct packed {
        logic last;
        logic drop;
    } t_item_ctl;

    // back-end sequencer
    typedef enum logic [4:0] {
        S_LOAD,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_START,
        S_LEFT,
        S_RIGHT,
        S_F_RD,
        S_F_GET,
        S_F_TURN,
        S_SCAN,
        S_S_TURN,
        S_POP_RD,
        S_POP_GET,
        S_SHORT,
        S_E_RD,
        S_E_OUT
    } t_state;

endpackage
`default_nettype wire

>>> hdl/chull_ifs.sv
// Interfaces: point input channel and hull vertex output channel.
`default_nettype none
interface chull_point_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic                last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

interface chull_hull_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] hull_x;
    logic signed [W-1:0] hull_y;
    logic                final_vertex;
    logic [1:0]          status;

    modport source (output valid, output hull_x, output hull_y, output final_vertex,
                    output status, input ready);
    modport sink   (input valid, input hull_x, input hull_y, input final_vertex,
                    input status, output ready);
endinterface
`default_nettype wire

>>> hdl/chull_fifo.sv
// Short queue between the front and back parts.
`default_nettype none
module chull_fifo #(
    parameter int DW = 50
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    output logic               o_valid,
    output logic [DW-1:0]      o_data,
    input  wire logic          i_pop
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [DW-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hdl/chull_front.sv
// Front part: takes points, tags capacity overflow and end of set, feeds the queue.
`default_nettype none
module chull_front #(
    parameter int MAX_POINTS = 64,
    parameter int W          = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    chull_point_if.sink              i_pt,
    input  wire logic                i_full,
    output logic                     o_push,
    output logic signed [W-1:0]      o_x,
    output logic signed [W-1:0]      o_y,
    output chull_pkg::t_item_ctl     o_ctl
);
    import chull_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] r_cnt;

    assign i_pt.ready = !i_full;
    assign o_push     = i_pt.valid && !i_full;
    assign o_x        = i_pt.point_x;
    assign o_y        = i_pt.point_y;
    assign o_ctl.last = i_pt.last_point;
    assign o_ctl.drop = (r_cnt == CW'(MAX_POINTS));

    // points held for the current set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_push) begin
            if (i_pt.last_point)  r_cnt <= '0;
            else if (!o_ctl.drop) r_cnt <= r_cnt + 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> hdl/chull_cross.sv
// Pipelined orientation test: sign of (b-a) x (c-a), with registered differences, products and sign.
`default_nettype none
module chull_cross #(
    parameter int W = 24
) (
    input  wire logic                i_clk,
    input  wire logic signed [W-1:0] i_ax,
    input  wire logic signed [W-1:0] i_ay,
    input  wire logic signed [W-1:0] i_bx,
    input  wire logic signed [W-1:0] i_by,
    input  wire logic signed [W-1:0] i_cx,
    input  wire logic signed [W-1:0] i_cy,
    output logic                     o_pos,
    output logic                     o_neg
);
    logic signed [W:0]     r_d1, r_d2, r_d3, r_d4;
    logic signed [2*W+1:0] r_m1, r_m2;
    logic signed [2*W+2:0] diff;

    assign diff = {r_m1[2*W+1], r_m1} - {r_m2[2*W+1], r_m2};

    // differences, products, then the sign of their difference
    always_ff @(posedge i_clk) begin
        r_d1  <= {i_bx[W-1], i_bx} - {i_ax[W-1], i_ax};
        r_d2  <= {i_cy[W-1], i_cy} - {i_ay[W-1], i_ay};
        r_d3  <= {i_by[W-1], i_by} - {i_ay[W-1], i_ay};
        r_d4  <= {i_cx[W-1], i_cx} - {i_ax[W-1], i_ax};
        r_m1  <= r_d1 * r_d2;
        r_m2  <= r_d3 * r_d4;
        o_pos <= !diff[2*W+2] && (diff != '0);
        o_neg <= diff[2*W+2];
    end
endmodule
`default_nettype wire

>>> hdl/chull_back.sv
// Back part: insertion sort at load, chain split, stack scan and vertex output.
`default_nettype none
module chull_back #(
    parameter int MAX_POINTS = 64,
    parameter int W          = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire logic signed [W-1:0]  i_q_x,
    input  wire logic signed [W-1:0]  i_q_y,
    input  wire chull_pkg::t_item_ctl i_q_ctl,
    output logic                      o_q_pop,
    chull_hull_if.source              o_hull
);
    import chull_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = $clog2(MAX_POINTS);

    // x in the upper half, y in the lower half
    logic [2*W-1:0] r_srt_mem [MAX_POINTS];
    logic [2*W-1:0] r_stk_mem [MAX_POINTS];
    logic [2*W-1:0] r_srt_rd, r_stk_rd;

    logic           srt_we, stk_we;
    logic [AW-1:0]  srt_wa, srt_ra, stk_wa, stk_ra;
    logic [2*W-1:0] srt_wd, stk_wd;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt, r_n, n_n, r_d, n_d;
    logic [AW-1:0] r_j, n_j, r_i, n_i;
    logic          r_ovf, n_ovf, r_last, n_last, r_pass, n_pass;
    logic [1:0]    r_wait, n_wait, r_stat, n_stat;
    logic [2*W-1:0] r_v, n_v, r_l, n_l, r_r, n_r, r_p, n_p, r_t, n_t, r_s, n_s;

    logic                r_ov, n_ov, r_fin, n_fin;
    logic signed [W-1:0] r_hx, n_hx, r_hy, n_hy;
    logic [1:0]          r_st, n_st;
    logic                slot_free;

    logic signed [W-1:0] ax, ay, bx, by, cx, cy;
    logic                cr_pos, cr_neg;

    // strict x-then-y order
    function automatic logic precedes(input logic [2*W-1:0] a, input logic [2*W-1:0] b);
        logic signed [W-1:0] a_x, a_y, b_x, b_y;
        a_x = a[2*W-1:W];
        a_y = a[W-1:0];
        b_x = b[2*W-1:W];
        b_y = b[W-1:0];
        return (a_x < b_x) || ((a_x == b_x) && (a_y < b_y));
    endfunction

    chull_cross #(.W(W)) u_cross (
        .i_clk (i_clk),
        .i_ax  (ax), .i_ay (ay),
        .i_bx  (bx), .i_by (by),
        .i_cx  (cx), .i_cy (cy),
        .o_pos (cr_pos),
        .o_neg (cr_neg)
    );

    // turn operands: chain split uses leftmost/rightmost, scan uses stack top pair
    always_comb begin
        if (r_state == S_F_TURN) begin
            ax = r_l[2*W-1:W]; ay = r_l[W-1:0];
            bx = r_r[2*W-1:W]; by = r_r[W-1:0];
        end else begin
            ax = r_s[2*W-1:W]; ay = r_s[W-1:0];
            bx = r_t[2*W-1:W]; by = r_t[W-1:0];
        end
        cx = r_p[2*W-1:W];
        cy = r_p[W-1:0];
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (srt_we) r_srt_mem[srt_wa] <= srt_wd;
        if (stk_we) r_stk_mem[stk_wa] <= stk_wd;
        r_srt_rd <= r_srt_mem[srt_ra];
        r_stk_rd <= r_stk_mem[stk_ra];
    end

    assign slot_free           = !r_ov || o_hull.ready;
    assign o_hull.valid        = r_ov;
    assign o_hull.hull_x       = r_hx;
    assign o_hull.hull_y       = r_hy;
    assign o_hull.final_vertex = r_fin;
    assign o_hull.status       = r_st;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_d     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_d     <= n_d;
            r_ov    <= n_ov;
        end
        r_n    <= n_n;    r_j  <= n_j;  r_i  <= n_i;
        r_last <= n_last; r_pass <= n_pass; r_wait <= n_wait; r_stat <= n_stat;
        r_v <= n_v; r_l <= n_l; r_r <= n_r; r_p <= n_p; r_t <= n_t; r_s <= n_s;
        r_hx <= n_hx; r_hy <= n_hy; r_fin <= n_fin; r_st <= n_st;
    end

    // sequencer
    always_comb begin
        logic [CW-1:0] d_after;
        logic          do_push, do_adv;
        n_state = r_state;
        n_cnt = r_cnt; n_n = r_n; n_d = r_d; n_j = r_j; n_i = r_i;
        n_ovf = r_ovf; n_last = r_last; n_pass = r_pass; n_wait = r_wait; n_stat = r_stat;
        n_v = r_v; n_l = r_l; n_r = r_r; n_p = r_p; n_t = r_t; n_s = r_s;
        n_hx = r_hx; n_hy = r_hy; n_fin = r_fin; n_st = r_st;
        n_ov = r_ov && !o_hull.ready;
        o_q_pop = 1'b0;
        srt_we = 1'b0; srt_wa = r_j; srt_wd = r_v; srt_ra = r_i;
        stk_we = 1'b0; stk_wa = r_d[AW-1:0]; stk_wd = r_p; stk_ra = r_i;
        do_push = 1'b0;
        do_adv  = 1'b0;
        d_after = r_d;

        unique case (r_state)
            S_LOAD: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_ctl.drop) begin
                        n_ovf = 1'b1;
                        if (i_q_ctl.last) n_state = S_START;
                    end else begin
                        n_v    = {i_q_x, i_q_y};
                        n_last = i_q_ctl.last;
                        n_j    = r_cnt[AW-1:0];
                        if (r_cnt == '0) begin
                            srt_we  = 1'b1;
                            srt_wa  = '0;
                            srt_wd  = {i_q_x, i_q_y};
                            n_cnt   = r_cnt + 1'b1;
                            n_state = i_q_ctl.last ? S_START : S_LOAD;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                end
            end
            S_INS_RD: begin
                srt_ra  = r_j - 1'b1;
                n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                srt_we = 1'b1;
                srt_wa = r_j;
                if (precedes(r_v, r_srt_rd)) begin
                    srt_wd  = r_srt_rd;
                    n_j     = r_j - 1'b1;
                    n_state = (r_j == AW'(1)) ? S_INS_PUT : S_INS_RD;
                end else begin
                    srt_wd  = r_v;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = r_last ? S_START : S_LOAD;
                end
            end
            S_INS_PUT: begin
                srt_we  = 1'b1;
                srt_wa  = '0;
                srt_wd  = r_v;
                n_cnt   = r_cnt + 1'b1;
                n_state = r_last ? S_START : S_LOAD;
            end
            S_START: begin
                n_n    = r_cnt;
                n_stat = r_ovf ? ST_OVF : ST_OK;
                n_cnt  = '0;
                n_ovf  = 1'b0;
                srt_ra = '0;
                n_state = (r_cnt < CW'(MIN_HULL_POINTS)) ? S_SHORT : S_LEFT;
            end
            S_LEFT: begin
                n_l     = r_srt_rd;
                srt_ra  = AW'(r_n - 1'b1);
                n_state = S_RIGHT;
            end
            S_RIGHT: begin
                n_r    = r_srt_rd;
                stk_we = 1'b1;
                stk_wa = '0;
                stk_wd = r_l;
                n_t    = r_l;
                n_d    = CW'(1);
                n_pass = 1'b0;
                n_i    = AW'(1);
                n_state = S_F_RD;
            end
            S_F_RD: begin
                srt_ra  = r_i;
                n_state = S_F_GET;
            end
            S_F_GET: begin
                n_p     = r_srt_rd;
                n_wait  = '0;
                n_state = S_F_TURN;
            end
            S_F_TURN: begin
                if (r_wait != 2'd3) begin
                    n_wait = r_wait + 1'b1;
                end else if (r_pass ? !cr_neg : cr_neg) begin
                    n_state = S_SCAN;
                end else begin
                    do_adv = 1'b1;
                end
            end
            S_SCAN: begin
                if (r_d > CW'(1)) begin
                    n_wait  = '0;
                    n_state = S_S_TURN;
                end else begin
                    do_push = 1'b1;
                end
            end
            S_S_TURN: begin
                if (r_wait != 2'd3) begin
                    n_wait = r_wait + 1'b1;
                end else if (cr_pos) begin
                    do_push = 1'b1;
                end else begin
                    n_d     = r_d - 1'b1;
                    n_t     = r_s;
                    n_state = (r_d > CW'(2)) ? S_POP_RD : S_SCAN;
                end
            end
            S_POP_RD: begin
                stk_ra  = AW'(r_d - CW'(2));
                n_state = S_POP_GET;
            end
            S_POP_GET: begin
                n_s     = r_stk_rd;
                n_state = S_SCAN;
            end
            S_SHORT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_hx    = '0;
                    n_hy    = '0;
                    n_fin   = 1'b1;
                    n_st    = ST_FEW;
                    n_state = S_LOAD;
                end
            end
            S_E_RD: begin
                stk_ra  = r_i;
                n_state = S_E_OUT;
            end
            S_E_OUT: begin
                if (slot_free) begin
                    n_ov  = 1'b1;
                    n_hx  = r_stk_rd[2*W-1:W];
                    n_hy  = r_stk_rd[W-1:0];
                    n_fin = (r_i == '0);
                    n_st  = r_stat;
                    if (r_i == '0) begin
                        n_d     = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_i     = r_i - 1'b1;
                        n_state = S_E_RD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase

        // push the current walk point onto the stack
        if (do_push) begin
            stk_we  = 1'b1;
            stk_wa  = r_d[AW-1:0];
            stk_wd  = r_p;
            n_s     = r_t;
            n_t     = r_p;
            d_after = r_d + 1'b1;
            n_d     = d_after;
            do_adv  = 1'b1;
        end

        // step the walk: lower chain ascending, then upper chain descending
        if (do_adv) begin
            if (r_pass && r_i == AW'(1)) begin
                n_i     = AW'(d_after - 1'b1);
                n_state = S_E_RD;
            end else if (!r_pass && r_i == AW'(r_n - CW'(2))) begin
                n_pass  = 1'b1;
                n_i     = AW'(r_n - 1'b1);
                n_state = S_F_RD;
            end else begin
                n_i     = r_pass ? r_i - 1'b1 : r_i + 1'b1;
                n_state = S_F_RD;
            end
        end
    end
endmodule
`default_nettype wire

>>> hdl/convex_hull_2d_core.sv
// Top level: 2D convex hull core, front part, queue and back part.
//
// Points enter on i_pt, one transfer per point; the point with last_point set
// closes the set and starts the hull run. Vertices leave on o_hull newest
// first, final_vertex marking the last one; status is 0 ok, 2 when points
// beyond MAX_POINTS were dropped, and a set of fewer than four points gives a
// single result with status 1 and zero coordinates.
// Loading: a 4-entry queue takes a point every cycle while it has room; the
// back part drains it with an insertion sort. The first point of a set is
// written directly; a later one is compared with the stored points from the
// top down, each larger one moving up one slot until its place is found.
// Run: the end points are fetched, then the chain split walks the points in
// two passes; each scan turn test waits on the 3-stage orientation pipeline,
// each pop reads the stack, and each vertex is read back and emitted.
// The output is registered: a stalled receiver holds the current vertex and
// stops the back part; the queue keeps accepting points until full.
// Reset (synchronous, active low) empties the queue, clears counts and flags
// and drops any run in progress; the point memories need no clearing.
`default_nettype none
module convex_hull_2d_core #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 24
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    chull_point_if.sink  i_pt,
    chull_hull_if.source o_hull
);
    import chull_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = 2*W + $bits(t_item_ctl);

    logic                f_push, q_full, q_valid, q_pop;
    logic signed [W-1:0] f_x, f_y;
    t_item_ctl           f_ctl, q_ctl;
    logic [DW-1:0]       q_data;

    chull_front #(.MAX_POINTS(MAX_POINTS), .W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_full  (q_full),
        .o_push  (f_push),
        .o_x     (f_x),
        .o_y     (f_y),
        .o_ctl   (f_ctl)
    );

    chull_fifo #(.DW(DW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_x, f_y, f_ctl}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    assign q_ctl = q_data[$bits(t_item_ctl)-1:0];

    chull_back #(.MAX_POINTS(MAX_POINTS), .W(W)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_x     (q_data[DW-1:DW-W]),
        .i_q_y     (q_data[W+$bits(t_item_ctl)-1:$bits(t_item_ctl)]),
        .i_q_ctl   (q_ctl),
        .o_q_pop   (q_pop),
        .o_hull    (o_hull)
    );
endmodule
`default_nettype wire

>>> tb/sv/convex_hull_2d_core_test.sv
// Testbench: convex hull core checked against a behavioral hull predictor.
`default_nettype none
module convex_hull_2d_core_test;
    import chull_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 64;
    localparam int CW = 24;
    localparam int WATCHDOG = 400000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } t_point;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 fin;
        logic [1:0]           st;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    chull_point_if #(.W(CW)) pt_if ();
    chull_hull_if  #(.W(CW)) hull_if ();

    convex_hull_2d_core #(.MAX_POINTS(NPTS), .COORD_BITS(CW)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if.sink),
        .o_hull (hull_if.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic signed [CW-1:0] set_x[NPTS];
    logic signed [CW-1:0] set_y[NPTS];
    int     set_count = 0;
    bit     set_overflow = 0;

    t_point  pending_pts[$];
    t_vertex hull_expect[$];
    int      fails = 0;
    int      idle_cycles = 0;
    bit      feed_done = 0;
    bit      in_xfer = 0;

    // orientation of (b-a) x (c-a): 1 left, -1 right, 0 collinear
    function automatic int orient(int a, int b, int c);
        longint lhs, rhs;
        lhs = (longint'(set_x[b]) - set_x[a]) * (longint'(set_y[c]) - set_y[a]);
        rhs = (longint'(set_y[b]) - set_y[a]) * (longint'(set_x[c]) - set_x[a]);
        return (lhs > rhs) ? 1 : (lhs < rhs) ? -1 : 0;
    endfunction

    function automatic bit lower_first(int a, int b);
        if (set_x[a] == set_x[b]) return set_y[a] < set_y[b];
        return set_x[a] < set_x[b];
    endfunction

    // store one point; on the closing point compute the hull vertices
    task automatic predict_hull(t_point p);
        int sorted[NPTS];
        int path[NPTS];
        int stk[NPTS];
        int n, plen, depth, i, j, v;
        logic [1:0] st;
        t_vertex vtx;
        if (set_count < NPTS) begin
            set_x[set_count] = p.x;
            set_y[set_count] = p.y;
            set_count++;
        end else begin
            set_overflow = 1;
        end
        if (!p.last) return;
        n = set_count;
        st = set_overflow ? ST_OVF : ST_OK;
        set_count = 0;
        set_overflow = 0;
        if (n < MIN_HULL_POINTS) begin
            vtx = '{x: '0, y: '0, fin: 1'b1, st: ST_FEW};
            hull_expect.insert(hull_expect.size(), vtx);
            return;
        end
        for (i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && lower_first(i, sorted[j-1])) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = i;
        end
        plen = 0;
        path[plen++] = sorted[0];
        for (i = 0; i < n; i++)
            if (orient(sorted[0], sorted[n-1], sorted[i]) < 0) path[plen++] = sorted[i];
        for (i = n - 1; i >= 1; i--)
            if (orient(sorted[0], sorted[n-1], sorted[i]) >= 0) path[plen++] = sorted[i];
        stk[0] = path[0];
        stk[1] = path[1];
        depth = 2;
        i = 2;
        while (i < plen) begin
            if (depth > 1 && orient(stk[depth-2], stk[depth-1], path[i]) != 1) begin
                depth--;
            end else begin
                stk[depth++] = path[i++];
            end
        end
        for (i = depth - 1; i >= 0; i--) begin
            v = stk[i];
            vtx = '{x: set_x[v], y: set_y[v], fin: (i == 0), st: st};
            hull_expect.insert(hull_expect.size(), vtx);
        end
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // input transfer seen at the last rising edge
    always @(posedge i_clk) begin
        in_xfer <= pt_if.valid && pt_if.ready;
    end

    // driver: one transfer per queued point, random gaps
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else if (pt_if.valid && !in_xfer) begin
            // hold until transfer
        end else if (src_gap > 0) begin
            src_gap <= src_gap - 1;
            pt_if.valid <= 1'b0;
        end else if (pending_pts.size() > 0) begin
            pt_if.valid      <= 1'b1;
            pt_if.point_x    <= pending_pts[0].x;
            pt_if.point_y    <= pending_pts[0].y;
            pt_if.last_point <= pending_pts[0].last;
            pending_pts.delete(0);
            src_gap <= gap_len();
        end else begin
            pt_if.valid <= 1'b0;
        end
    end

    // receiver back-pressure
    int snk_gap = 0;
    always @(negedge i_clk) begin
        if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            hull_if.ready <= 1'b0;
        end else begin
            hull_if.ready <= 1'b1;
            snk_gap <= gap_len();
        end
    end

    // monitor: predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (i_rst_n) begin
            if ((pt_if.valid && pt_if.ready) || (hull_if.valid && hull_if.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (pt_if.valid && pt_if.ready) begin
                predict_hull('{x: pt_if.point_x, y: pt_if.point_y,
                               last: pt_if.last_point});
            end
            if (hull_if.valid && hull_if.ready) begin
                if (hull_expect.size() == 0) begin
                    $error("unexpected vertex x=%0d y=%0d", hull_if.hull_x, hull_if.hull_y);
                    fails++;
                end else begin
                    exp_v = hull_expect[0];
                    hull_expect.delete(0);
                    if (hull_if.hull_x !== exp_v.x) begin
                        $error("hull_x expected %0d got %0d", exp_v.x, hull_if.hull_x);
                        fails++;
                    end
                    if (hull_if.hull_y !== exp_v.y) begin
                        $error("hull_y expected %0d got %0d", exp_v.y, hull_if.hull_y);
                        fails++;
                    end
                    if (hull_if.final_vertex !== exp_v.fin) begin
                        $error("final_vertex expected %0d got %0d", exp_v.fin,
                               hull_if.final_vertex);
                        fails++;
                    end
                    if (hull_if.status !== exp_v.st) begin
                        $error("status expected %0d got %0d", exp_v.st, hull_if.status);
                        fails++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_point(int x, int y, bit last);
        t_point pt;
        pt = '{x: x[CW-1:0], y: y[CW-1:0], last: last};
        pending_pts.insert(pending_pts.size(), pt);
    endtask

    // one closed set of n points; mode picks the coordinate spread
    task automatic add_set(int n, int mode);
        int k, r, base;
        base = $urandom_range(0, 255) - 128;
        for (k = 0; k < n; k++) begin
            case (mode)
                0: add_point($urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16, k == n-1);
                1: add_point($urandom, $urandom, k == n-1);
                2: begin
                    r = $urandom_range(0, 20);
                    add_point(base + r, 2 * r - 7, k == n-1);
                end
                default: add_point($urandom_range(0, 3), $urandom_range(0, 3), k == n-1);
            endcase
        end
    endtask

    int sent;
    int n;
    initial begin
        pt_if.valid = 1'b0;
        pt_if.point_x = '0;
        pt_if.point_y = '0;
        pt_if.last_point = 1'b0;
        hull_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: small sets, extremes, square with collinear and duplicate points
        add_point(5, 5, 1);
        add_point(1, 2, 0); add_point(3, 4, 0); add_point(-1, 0, 1);
        add_point(-8388608, -8388608, 0); add_point(8388607, -8388608, 0);
        add_point(8388607, 8388607, 0); add_point(-8388608, 8388607, 1);
        add_point(0, 0, 0); add_point(4, 0, 0); add_point(2, 0, 0);
        add_point(4, 4, 0); add_point(4, 4, 0); add_point(0, 4, 0);
        add_point(2, 2, 1);
        add_point(0, 0, 0); add_point(1, 1, 0); add_point(2, 2, 0); add_point(3, 3, 1);
        add_point(7, 7, 0); add_point(7, 7, 0); add_point(7, 7, 0); add_point(7, 7, 1);
        // capacity overflow, closing point dropped as well
        for (int k = 0; k < NPTS + 3; k++)
            add_point($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                      k == NPTS + 2);
        sent = 0;
        while (sent < 150) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
            add_set(n, $urandom_range(0, 3));
            sent += n;
        end
        add_set(NPTS, 1);
        while (pending_pts.size() > 0 || pt_if.valid) @(posedge i_clk);
        while (hull_expect.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
